// File: rtl/core/spt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;

   localparam int SEG_SLOTS   = 16;
   localparam int PAGE_SLOTS  = 16;
   localparam int PAGE_DEPTH  = SEG_SLOTS * PAGE_SLOTS;
   localparam int SEG_IDX_W   = (SEG_SLOTS > 1) ? $clog2(SEG_SLOTS) : 1;
   localparam int PAGE_IDX_W  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
   localparam int PAGE_ADDR_W = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

   localparam int ADDR_W         = 32;
   localparam int SEG_NBITS_MAX  = 12;
   localparam int PAGE_NBITS_MAX = 20;

   // request actions
   localparam logic [1:0] ACT_TRANSLATE  = 2'd0;
   localparam logic [1:0] ACT_SEG_WRITE  = 2'd1;
   localparam logic [1:0] ACT_PAGE_WRITE = 2'd2;

   // response status codes
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_SEG_FAULT  = 2'd1;
   localparam logic [1:0] STAT_PAGE_FAULT = 2'd2;
   localparam logic [1:0] STAT_WRITTEN    = 2'd3;

   // register file
   localparam int         CSR_ADDR_W     = 3;
   localparam logic       CSR_SEG_NBITS  = 1'b0;
   localparam logic       CSR_PAGE_NBITS = 1'b1;
   localparam logic [3:0] SEG_NBITS_RST  = 4'd4;
   localparam logic [4:0] PAGE_NBITS_RST = 5'd8;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] virtual_address;
      logic [3:0]  seg_slot;
      logic [3:0]  page_slot;
      logic        entry_valid;
      logic [11:0] seg_id;
      logic [31:0] seg_length;
      logic [19:0] page_id;
      logic [19:0] frame;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] seg_field;
      logic [30:0] seg_offset;
      logic [19:0] page_field;
      logic [30:0] page_offset;
      logic [31:0] physical_address;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_SEG    = 6'b000100,
      S_PAGE   = 6'b001000,
      S_FINISH = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       seg_scan;
      logic       page_scan;
      logic       finish;
      logic       set_status;
      logic [1:0] status;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic seg_match;
      logic seg_in_limit;
      logic seg_last;
      logic page_hit;
      logic page_miss;
   } stat_type;

endpackage
`default_nettype wire

// File: rtl/core/spt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module spt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_action,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire spt_pkg::stat_type stat,
   output spt_pkg::cmd_type      cmd
);

   spt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;

   assign req_ready = (state_ff == spt_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         spt_pkg::S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_action == spt_pkg::ACT_TRANSLATE) begin
                  state_in = spt_pkg::S_DECODE;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = spt_pkg::STAT_WRITTEN;
                  state_in       = spt_pkg::S_EMIT;
               end
            end
         end
         spt_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = spt_pkg::S_SEG;
         end
         spt_pkg::S_SEG: begin
            cmd.seg_scan = 1'b1;
            if (stat.seg_match && stat.seg_in_limit) begin
               state_in = spt_pkg::S_PAGE;
            end else if (stat.seg_match || stat.seg_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = spt_pkg::STAT_SEG_FAULT;
               state_in       = spt_pkg::S_EMIT;
            end
         end
         spt_pkg::S_PAGE: begin
            cmd.page_scan = 1'b1;
            if (stat.page_hit) begin
               state_in = spt_pkg::S_FINISH;
            end else if (stat.page_miss) begin
               cmd.set_status = 1'b1;
               cmd.status     = spt_pkg::STAT_PAGE_FAULT;
               state_in       = spt_pkg::S_EMIT;
            end
         end
         spt_pkg::S_FINISH: begin
            cmd.finish     = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = spt_pkg::STAT_OK;
            state_in       = spt_pkg::S_EMIT;
         end
         spt_pkg::S_EMIT: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = spt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/spt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module spt_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire spt_pkg::cmd_type cmd,
   input  wire spt_pkg::req_type req_data,
   input  wire logic [3:0]       seg_nbits,
   input  wire logic [4:0]       page_nbits,
   output spt_pkg::stat_type     stat,
   output spt_pkg::rsp_type      rsp_data
);

   localparam int SW = spt_pkg::SEG_IDX_W;
   localparam int PW = spt_pkg::PAGE_IDX_W;
   localparam int AW = spt_pkg::PAGE_ADDR_W;

   // segment table: small register file, read at the scan index only
   logic [spt_pkg::SEG_SLOTS-1:0]  seg_valid_ff;
   logic [11:0]                    seg_id_mem  [spt_pkg::SEG_SLOTS];
   logic [31:0]                    seg_len_mem [spt_pkg::SEG_SLOTS];

   // page table: valid bits in flops, payload in memory
   logic [spt_pkg::PAGE_DEPTH-1:0] page_valid_ff;
   logic [19:0]                    page_id_mem [spt_pkg::PAGE_DEPTH];
   logic [19:0]                    frame_mem   [spt_pkg::PAGE_DEPTH];

   logic [31:0] va_ff;
   logic [11:0] sfield_ff;
   logic [30:0] soff_ff;
   logic [19:0] pfield_ff;
   logic [30:0] poff_ff;
   logic [5:0]  obits_ff;
   logic [SW-1:0] seg_idx_ff;
   logic [SW-1:0] hit_slot_ff;
   logic [PW-1:0] pg_idx_ff;
   logic          rd_pend_ff;
   logic          rd_last_ff;
   logic          pvalid_rd_ff;
   logic [19:0]   pid_rd_ff;
   logic [19:0]   frame_rd_ff;
   logic [19:0]   frame_hit_ff;
   logic [31:0]   phys_ff;
   logic [1:0]    status_ff;
   spt_pkg::rsp_type rsp_ff;

   // decode
   logic [3:0]  s_eff;
   logic [4:0]  p_eff;
   logic [5:0]  soff_w;
   logic [5:0]  o_w;
   logic [31:0] sfield_in, soff_in, pfield_in, poff_in;

   logic          seg_wr, page_wr;
   logic [SW-1:0] wr_seg_idx;
   logic [AW-1:0] wr_page_addr;
   logic [AW-1:0] rd_page_addr;
   logic          seg_last, page_hit;

   always_comb begin
      if (seg_nbits == 4'd0) begin
         s_eff = 4'd1;
      end else if (seg_nbits > 4'(spt_pkg::SEG_NBITS_MAX)) begin
         s_eff = 4'(spt_pkg::SEG_NBITS_MAX);
      end else begin
         s_eff = seg_nbits;
      end
      p_eff     = (page_nbits > 5'(spt_pkg::PAGE_NBITS_MAX)) ?
                  5'(spt_pkg::PAGE_NBITS_MAX) : page_nbits;
      soff_w    = 6'(spt_pkg::ADDR_W) - {2'b00, s_eff};
      o_w       = soff_w - {1'b0, p_eff};
      sfield_in = va_ff >> soff_w;
      soff_in   = va_ff & ((32'h1 << soff_w) - 32'h1);
      pfield_in = (va_ff >> o_w) & ((32'h1 << p_eff) - 32'h1);
      poff_in   = va_ff & ((32'h1 << o_w) - 32'h1);
   end

   assign seg_wr = cmd.capture && (req_data.action == spt_pkg::ACT_SEG_WRITE) &&
                   (32'(req_data.seg_slot) < spt_pkg::SEG_SLOTS);
   assign page_wr = cmd.capture && (req_data.action == spt_pkg::ACT_PAGE_WRITE) &&
                    (32'(req_data.seg_slot) < spt_pkg::SEG_SLOTS) &&
                    (32'(req_data.page_slot) < spt_pkg::PAGE_SLOTS);
   assign wr_seg_idx   = SW'(req_data.seg_slot);
   assign wr_page_addr = AW'(32'(req_data.seg_slot) * spt_pkg::PAGE_SLOTS +
                             32'(req_data.page_slot));
   assign rd_page_addr = AW'(32'(hit_slot_ff) * spt_pkg::PAGE_SLOTS + 32'(pg_idx_ff));

   assign seg_last = (seg_idx_ff == SW'(spt_pkg::SEG_SLOTS - 1));
   assign page_hit = rd_pend_ff && pvalid_rd_ff && (pid_rd_ff == pfield_ff);

   assign stat.seg_match    = seg_valid_ff[seg_idx_ff] &&
                              (seg_id_mem[seg_idx_ff] == sfield_ff);
   assign stat.seg_in_limit = ({1'b0, soff_ff} < seg_len_mem[seg_idx_ff]);
   assign stat.seg_last     = seg_last;
   assign stat.page_hit     = page_hit;
   assign stat.page_miss    = rd_pend_ff && !page_hit && rd_last_ff;

   assign rsp_data = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_valid_ff  <= '0;
         page_valid_ff <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         if (seg_wr) begin
            seg_valid_ff[wr_seg_idx] <= req_data.entry_valid;
         end
         if (page_wr) begin
            page_valid_ff[wr_page_addr] <= req_data.entry_valid;
         end
         rd_pend_ff <= cmd.page_scan;
      end
   end

   // table payload
   always_ff @(posedge clock) begin
      if (seg_wr) begin
         seg_id_mem[wr_seg_idx]  <= req_data.seg_id;
         seg_len_mem[wr_seg_idx] <= req_data.seg_length;
      end
      if (page_wr) begin
         page_id_mem[wr_page_addr] <= req_data.page_id;
         frame_mem[wr_page_addr]   <= req_data.frame;
      end
      if (cmd.page_scan) begin
         pid_rd_ff    <= page_id_mem[rd_page_addr];
         frame_rd_ff  <= frame_mem[rd_page_addr];
         pvalid_rd_ff <= page_valid_ff[rd_page_addr];
         rd_last_ff   <= (pg_idx_ff == PW'(spt_pkg::PAGE_SLOTS - 1));
      end
   end

   // translation datapath
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff <= req_data.virtual_address;
      end
      if (cmd.decode) begin
         sfield_ff  <= sfield_in[11:0];
         soff_ff    <= soff_in[30:0];
         pfield_ff  <= pfield_in[19:0];
         poff_ff    <= poff_in[30:0];
         obits_ff   <= o_w;
         seg_idx_ff <= '0;
         pg_idx_ff  <= '0;
      end
      if (cmd.seg_scan) begin
         if (stat.seg_match) begin
            hit_slot_ff <= seg_idx_ff;
         end else if (!seg_last) begin
            seg_idx_ff <= seg_idx_ff + SW'(1);
         end
      end
      if (cmd.page_scan) begin
         if (pg_idx_ff != PW'(spt_pkg::PAGE_SLOTS - 1)) begin
            pg_idx_ff <= pg_idx_ff + PW'(1);
         end
         if (page_hit) begin
            frame_hit_ff <= frame_rd_ff;
         end
      end
      if (cmd.finish) begin
         phys_ff <= (32'(frame_hit_ff) << obits_ff) + {1'b0, poff_ff};
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.emit) begin
         rsp_ff.status <= status_ff;
         if (status_ff == spt_pkg::STAT_WRITTEN) begin
            rsp_ff.seg_field        <= '0;
            rsp_ff.seg_offset       <= '0;
            rsp_ff.page_field       <= '0;
            rsp_ff.page_offset      <= '0;
            rsp_ff.physical_address <= '0;
         end else begin
            rsp_ff.seg_field        <= sfield_ff;
            rsp_ff.seg_offset       <= soff_ff;
            rsp_ff.page_field       <= pfield_ff;
            rsp_ff.page_offset      <= poff_ff;
            rsp_ff.physical_address <= (status_ff == spt_pkg::STAT_OK) ? phys_ff : '0;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/segmented_paging_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  spt_pkg::req_type
// rsp       out        rsp_valid/rsp_ready  spt_pkg::rsp_type
// csr       in/out     APB, pready tied 1   seg_nbits @0x0, page_nbits @0x4
//
// A table write goes straight to the response. A hit scans k segment slots
// (1..SEG_SLOTS) and m page slots (1..PAGE_SLOTS, one per cycle through the
// registered page memory port); a segment fault scans k segment slots, a page
// fault every page slot. Reset clears the valid bits and handshake state and
// presets the CSRs. The response register holds a result while rsp_ready is
// low; a new request is taken meanwhile and stalls only when its own result is ready to leave.
module segmented_paging_translator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire spt_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output spt_pkg::rsp_type                         rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [spt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);

   logic [3:0] seg_nbits_ff;
   logic [4:0] page_nbits_ff;
   logic       csr_wr;

   spt_pkg::cmd_type  cmd;
   spt_pkg::stat_type stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_nbits_ff  <= spt_pkg::SEG_NBITS_RST;
         page_nbits_ff <= spt_pkg::PAGE_NBITS_RST;
      end else if (csr_wr) begin
         unique case (paddr[2])
            spt_pkg::CSR_SEG_NBITS:  seg_nbits_ff  <= pwdata[3:0];
            spt_pkg::CSR_PAGE_NBITS: page_nbits_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         spt_pkg::CSR_SEG_NBITS:  prdata = {28'd0, seg_nbits_ff};
         spt_pkg::CSR_PAGE_NBITS: prdata = {27'd0, page_nbits_ff};
         default:                 prdata = '0;
      endcase
   end

   spt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .seg_nbits  (seg_nbits_ff),
      .page_nbits (page_nbits_ff),
      .stat       (stat),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/core/spt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module spt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire spt_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire spt_pkg::rsp_type rsp_data
);

   // an accepted request keeps the engine busy, so requests are never taken back to back
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   a_written_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == spt_pkg::STAT_WRITTEN) |->
      (rsp_data.seg_field == '0 && rsp_data.seg_offset == '0 &&
       rsp_data.page_field == '0 && rsp_data.page_offset == '0 &&
       rsp_data.physical_address == '0))
      else $error("write response carries data");

   a_fault_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == spt_pkg::STAT_SEG_FAULT ||
                     rsp_data.status == spt_pkg::STAT_PAGE_FAULT)) |->
      (rsp_data.physical_address == '0))
      else $error("fault response carries an address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind segmented_paging_translator spt_checker u_spt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import spt_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] SEG_NBITS_ADDR  = {CSR_SEG_NBITS, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] PAGE_NBITS_ADDR = {CSR_PAGE_NBITS, 2'b00};
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]           pwdata  = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // mirror of the translation tables and registers
   logic        seg_live    [SEG_SLOTS]  = '{default: 1'b0};
   logic [11:0] seg_id_tab  [SEG_SLOTS]  = '{default: '0};
   logic [31:0] seg_len_tab [SEG_SLOTS]  = '{default: '0};
   logic        page_live   [PAGE_DEPTH] = '{default: 1'b0};
   logic [19:0] page_id_tab [PAGE_DEPTH] = '{default: '0};
   logic [19:0] frame_tab   [PAGE_DEPTH] = '{default: '0};
   logic [3:0]  seg_nbits_reg  = SEG_NBITS_RST;
   logic [4:0]  page_nbits_reg = PAGE_NBITS_RST;

   rsp_type expected_rsp[$];
   int      mismatch_count = 0;
   logic    req_steady     = 1'b0;
   logic    ready_steady   = 1'b0;
   logic    hold_pending   = 1'b0;
   int      ready_wait     = 0;

   segmented_paging_translator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] low_ones(input int unsigned n);
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic int unsigned seg_width();
      if (seg_nbits_reg < 1) return 1;
      if (seg_nbits_reg > SEG_NBITS_MAX) return SEG_NBITS_MAX;
      return seg_nbits_reg;
   endfunction

   function automatic int unsigned page_width();
      if (page_nbits_reg > PAGE_NBITS_MAX) return PAGE_NBITS_MAX;
      return page_nbits_reg;
   endfunction

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Update the table mirror and work out the response for one request.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type     res;
      int unsigned s, p, o;
      int          seg_hit, page_hit, base, i;
      logic [63:0] va, sfield, soff, pfield, poff, phys;
      res = '0;
      if (r.action != ACT_TRANSLATE) begin
         if (r.action == ACT_SEG_WRITE) begin
            seg_live[r.seg_slot]    = r.entry_valid;
            seg_id_tab[r.seg_slot]  = r.seg_id;
            seg_len_tab[r.seg_slot] = r.seg_length;
         end else if (r.action == ACT_PAGE_WRITE) begin
            base = int'(r.seg_slot) * PAGE_SLOTS + int'(r.page_slot);
            page_live[base]   = r.entry_valid;
            page_id_tab[base] = r.page_id;
            frame_tab[base]   = r.frame;
         end
         res.status = STAT_WRITTEN;
         return res;
      end
      s = seg_width();
      p = page_width();
      o = ADDR_W - s - p;
      va = 64'(r.virtual_address);
      sfield = va >> (ADDR_W - s);
      soff   = va & low_ones(ADDR_W - s);
      pfield = (va >> o) & low_ones(p);
      poff   = va & low_ones(o);
      res.seg_field   = sfield[11:0];
      res.seg_offset  = soff[30:0];
      res.page_field  = pfield[19:0];
      res.page_offset = poff[30:0];
      seg_hit = -1;
      for (i = 0; i < SEG_SLOTS && seg_hit < 0; i++) begin
         if (seg_live[i] && 64'(seg_id_tab[i]) == sfield) seg_hit = i;
      end
      if (seg_hit < 0 || soff >= 64'(seg_len_tab[seg_hit])) begin
         res.status = STAT_SEG_FAULT;
         return res;
      end
      page_hit = -1;
      base = seg_hit * PAGE_SLOTS;
      for (i = 0; i < PAGE_SLOTS && page_hit < 0; i++) begin
         if (page_live[base + i] && 64'(page_id_tab[base + i]) == pfield) page_hit = base + i;
      end
      if (page_hit < 0) begin
         res.status = STAT_PAGE_FAULT;
         return res;
      end
      phys = (64'(frame_tab[page_hit]) << o) + poff;
      res.status = STAT_OK;
      res.physical_address = phys[31:0];
      return res;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.action          = 2'($urandom());
      r.virtual_address = $urandom();
      r.seg_slot        = 4'($urandom());
      r.page_slot       = 4'($urandom());
      r.entry_valid     = 1'($urandom());
      r.seg_id          = 12'($urandom());
      r.seg_length      = $urandom();
      r.page_id         = 20'($urandom());
      r.frame           = 20'($urandom());
      return r;
   endfunction

   function automatic req_type seg_entry(input int slot, input logic live,
                                         input logic [11:0] id, input logic [31:0] len);
      req_type r;
      r = random_request();
      r.action      = ACT_SEG_WRITE;
      r.seg_slot    = 4'(slot);
      r.entry_valid = live;
      r.seg_id      = id;
      r.seg_length  = len;
      return r;
   endfunction

   function automatic req_type page_entry(input int sslot, input int pslot, input logic live,
                                          input logic [19:0] id, input logic [19:0] frm);
      req_type r;
      r = random_request();
      r.action      = ACT_PAGE_WRITE;
      r.seg_slot    = 4'(sslot);
      r.page_slot   = 4'(pslot);
      r.entry_valid = live;
      r.page_id     = id;
      r.frame       = frm;
      return r;
   endfunction

   function automatic req_type translate(input logic [31:0] va);
      req_type r;
      r = random_request();
      r.action          = ACT_TRANSLATE;
      r.virtual_address = va;
      return r;
   endfunction

   function automatic logic [31:0] compose_address(input logic [63:0] sfield,
                                                   input logic [63:0] pfield,
                                                   input logic [63:0] poff);
      int unsigned s, p, o;
      logic [63:0] va;
      s = seg_width();
      p = page_width();
      o = ADDR_W - s - p;
      va = (sfield << (ADDR_W - s)) | ((pfield & low_ones(p)) << o) | (poff & low_ones(o));
      return va[31:0];
   endfunction

   // Mostly table writes and translations that land on live entries, plus noise.
   function automatic req_type random_operation();
      req_type     r;
      int          roll, ss, k, i;
      int unsigned s, p;
      logic [63:0] pid;
      int          live_segs[$];
      int          live_pages[$];
      r = random_request();
      s = seg_width();
      p = page_width();
      for (i = 0; i < SEG_SLOTS; i++) begin
         if (seg_live[i]) live_segs.push_back(i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
         r.action = ACT_SEG_WRITE;
         r.entry_valid = ($urandom_range(0, 6) != 0);
         if ($urandom_range(0, 4) != 0) r.seg_id = 12'(64'(r.seg_id) & low_ones(s));
         case ($urandom_range(0, 3))
            0, 1: begin
               r.seg_length = '1;
            end
            2: begin
               r.seg_length = r.seg_length >> $urandom_range(0, 31);
            end
            default: ;
         endcase
      end else if (roll < 50) begin
         r.action = ACT_PAGE_WRITE;
         r.entry_valid = ($urandom_range(0, 6) != 0);
         if (live_segs.size() != 0 && $urandom_range(0, 3) != 0) begin
            r.seg_slot = 4'(live_segs[$urandom_range(0, live_segs.size() - 1)]);
         end
         if ($urandom_range(0, 4) != 0) r.page_id = 20'(64'(r.page_id) & low_ones(p));
      end else if (roll < 95) begin
         r.action = ACT_TRANSLATE;
         if (live_segs.size() != 0 && $urandom_range(0, 4) != 0) begin
            ss = live_segs[$urandom_range(0, live_segs.size() - 1)];
            for (i = 0; i < PAGE_SLOTS; i++) begin
               if (page_live[ss * PAGE_SLOTS + i]) live_pages.push_back(ss * PAGE_SLOTS + i);
            end
            if (live_pages.size() != 0 && $urandom_range(0, 6) != 0) begin
               k = live_pages[$urandom_range(0, live_pages.size() - 1)];
               pid = 64'(page_id_tab[k]);
            end else begin
               pid = 64'($urandom());
            end
            r.virtual_address = compose_address(64'(seg_id_tab[ss]), pid,
                                                {$urandom(), $urandom()});
         end
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      gap = req_steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_response(r));
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [31:0] seg_value, input logic [31:0] page_value);
      int idx;
      for (idx = 0; idx < 2; idx++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= (idx == 0) ? SEG_NBITS_ADDR : PAGE_NBITS_ADDR;
         pwdata  <= (idx == 0) ? seg_value : page_value;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         if (idx == 0) seg_nbits_reg = seg_value[3:0];
         else page_nbits_reg = page_value[4:0];
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_random_traffic(input int count);
      int n;
      for (n = 0; n < count; n++) send_request(random_operation());
   endtask

   // Reset settings: empty tables, length limits, duplicate ids, clearing entries.
   task automatic test_directed_tables();
      req_type r;
      send_request(translate(32'h0000_0000));
      send_request(translate(32'hFFFF_FFFF));
      send_request(seg_entry(0, 1'b1, 12'h003, 32'h0000_0400));
      send_request(seg_entry(5, 1'b1, 12'h003, 32'hFFFF_FFFF));
      send_request(seg_entry(15, 1'b1, 12'h00F, 32'hFFFF_FFFF));
      send_request(seg_entry(1, 1'b1, 12'h007, 32'h0000_0000));
      send_request(page_entry(0, 0, 1'b1, 20'h0_0000, 20'hF_FFFF));
      send_request(page_entry(15, 0, 1'b1, 20'h0_00FF, 20'hA_BCDE));
      send_request(page_entry(15, 1, 1'b1, 20'h0_00FF, 20'h1_2345));
      send_request(translate(32'h3000_03FF));
      send_request(translate(32'h3000_0400));
      send_request(translate(32'h7000_0000));
      send_request(translate(32'hFFFF_FFFF));
      send_request(translate(32'hF000_0000));
      send_request(seg_entry(0, 1'b0, 12'h003, 32'h0000_0400));
      send_request(translate(32'h3000_0000));
      send_request(page_entry(5, 7, 1'b1, 20'h0_0000, 20'h0_0001));
      send_request(translate(32'h3000_0010));
      send_request(page_entry(15, 0, 1'b0, 20'h0_00FF, 20'h0_0000));
      send_request(translate(32'hFFFF_FFFF));
      r = random_request();
      r.action = ACT_UNUSED;
      send_request(r);
      send_request(translate(32'hFFFF_FFFF));
   endtask

   // Smallest and largest field widths, including saturated register values.
   task automatic test_register_extremes();
      logic [31:0] seg_values  [5] = '{32'd0, 32'd1, 32'd12, 32'd15, 32'd3};
      logic [31:0] page_values [5] = '{32'd31, 32'd0, 32'd20, 32'd0, 32'd20};
      int          n;
      for (n = 0; n < 5; n++) begin
         drain_requests();
         write_config(seg_values[n], page_values[n]);
         send_request(seg_entry(14, 1'b1, 12'(low_ones(seg_width())), 32'hFFFF_FFFF));
         send_request(page_entry(14, 3, 1'b1, 20'(low_ones(page_width())), 20'hF_FFFF));
         send_request(translate(32'hFFFF_FFFF));
         send_request(translate(32'h0000_0000));
         run_random_traffic(100);
      end
   endtask

   task automatic test_random_settings();
      logic [31:0] seg_value, page_value;
      int          n;
      for (n = 0; n < 6; n++) begin
         drain_requests();
         seg_value  = $urandom_range(0, 15);
         page_value = $urandom_range(0, 31);
         if ($urandom_range(0, 1) != 0) begin
            seg_value  = seg_value | ($urandom() & 32'hFFFF_FFF0);
            page_value = page_value | ($urandom() & 32'hFFFF_FFE0);
         end
         write_config(seg_value, page_value);
         req_steady = ($urandom_range(0, 3) == 0);
         run_random_traffic(185);
      end
      req_steady = 1'b0;
   endtask

   // Hold the response side off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      req_steady   = 1'b1;
      hold_pending = 1'b1;
      run_random_traffic(60);
      req_steady   = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_pending) begin
         hold_pending = 1'b0;
         ready_wait   = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (ready_wait > 0) begin
         ready_wait--;
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 255) == 0) ready_steady = !ready_steady;
         rsp_ready <= 1'b1;
         if (!ready_steady) ready_wait = idle_len();
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_data.status));
            check_field("seg_field", 64'(want.seg_field), 64'(rsp_data.seg_field));
            check_field("seg_offset", 64'(want.seg_offset), 64'(rsp_data.seg_offset));
            check_field("page_field", 64'(want.page_field), 64'(rsp_data.page_field));
            check_field("page_offset", 64'(want.page_offset), 64'(rsp_data.page_offset));
            check_field("physical_address", 64'(want.physical_address),
                        64'(rsp_data.physical_address));
         end
      end
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tables();
      test_register_extremes();
      test_random_settings();
      test_backpressure();
      drain_requests();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/spt_pkg.sv
rtl/core/spt_ctrl.sv
rtl/core/spt_dp.sv
rtl/core/segmented_paging_translator.sv
rtl/core/spt_checker.sv
bench/tb_top.sv
